FILE: sv/dual_version_word_conflict_table_core_defines.svh
// ----------------------------------------------------------------------------
// Dual version word conflict table - assertion macros
// Shared concurrent assertion forms. Each use expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef DUAL_VERSION_WORD_CONFLICT_TABLE_CORE_DEFINES_SVH
`define DUAL_VERSION_WORD_CONFLICT_TABLE_CORE_DEFINES_SVH

// same-cycle implication
`define DVWC_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DVWC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/dvwc_pkg.sv
// ----------------------------------------------------------------------------
// Dual version word conflict table - package
// Word types, item kinds, controller states and control/status bundles.
// ----------------------------------------------------------------------------
package dvwc_pkg;

    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_EPOCH = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  tx_id;
        logic        read_only;
        logic [7:0]  word_index;
        logic [63:0] write_data;
    } in_t;

    typedef struct packed {
        logic [63:0] read_data;
        logic        ok;
    } out_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_DECIDE,
        ST_SWEEP,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load_item;
        logic cnt_clr;
        logic cnt_inc;
        logic clear_wr;
        logic mem_read;
        logic sweep_rd;
        logic commit;
        logic result_load;
    } cmd_t;

    typedef struct packed {
        logic cnt_last;
        logic item_epoch;
        logic out_free;
    } status_t;

endpackage

FILE: sv/dual_version_word_conflict_table_core.sv
// ----------------------------------------------------------------------------
// Dual version word conflict table - top level
// Two-copy word store with per-word reader/writer records for transactions.
// ----------------------------------------------------------------------------
// After reset the block clears both copies and all records, with in_ready
// low. A read or write word then goes through acceptance, the record/copy
// memory read, and decide and write back, which waits for a free output
// register; an epoch-end word goes on from the memory read into the sweep
// that reads and rewrites one record per cycle through the record memory's
// single read and write port. Every input word yields exactly one output
// word; the output register lets a new word be accepted while a result waits.
module dual_version_word_conflict_table_core
    import dvwc_pkg::*;
#(
    parameter int WORDS      = 256,
    parameter int WORD_BITS  = 64,
    parameter int TX_ID_BITS = 4
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  in_t  in_data,
    output logic out_valid,
    input  logic out_ready,
    output out_t out_data
);

    cmd_t    cmd;
    status_t status;

    dvwc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    dvwc_datapath #(
        .WORDS      (WORDS),
        .WORD_BITS  (WORD_BITS),
        .TX_ID_BITS (TX_ID_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .status    (status),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule

FILE: sv/dvwc_ctrl.sv
// ----------------------------------------------------------------------------
// Dual version word conflict table - controller
// Sequences reset clearing, access lookup/commit and the epoch-end sweep.
// ----------------------------------------------------------------------------
`include "dual_version_word_conflict_table_core_defines.svh"

module dvwc_ctrl
    import dvwc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (status.cnt_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                state_next = status.item_epoch ? ST_SWEEP : ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SWEEP:
            begin
                if (status.cnt_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                cmd.cnt_inc  = 1'b1;
            end
            ST_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.load_item = in_valid;
                cmd.cnt_clr   = in_valid;
            end
            ST_LOOKUP:
            begin
                cmd.mem_read = 1'b1;
            end
            ST_DECIDE:
            begin
                cmd.commit      = status.out_free;
                cmd.result_load = status.out_free;
            end
            ST_SWEEP:
            begin
                cmd.sweep_rd = 1'b1;
                cmd.cnt_inc  = 1'b1;
            end
            ST_FINISH:
            begin
                cmd.result_load = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    `DVWC_ASSERT_NEXT(a_accept_to_lookup, in_valid && in_ready, state_reg == ST_LOOKUP, "accepted word did not start lookup")
    `DVWC_ASSERT_NEXT(a_sweep_to_finish, (state_reg == ST_SWEEP) && status.cnt_last, state_reg == ST_FINISH, "sweep did not end after last word")
    `DVWC_ASSERT_IMPL(a_result_needs_slot, cmd.result_load, status.out_free, "result loaded into busy output")

endmodule

FILE: sv/dvwc_datapath.sv
// ----------------------------------------------------------------------------
// Dual version word conflict table - datapath
// Word copies, per-word conflict records, sweep counter and output register.
// ----------------------------------------------------------------------------
`include "dual_version_word_conflict_table_core_defines.svh"

module dvwc_datapath
    import dvwc_pkg::*;
#(
    parameter int WORDS      = 256,
    parameter int WORD_BITS  = 64,
    parameter int TX_ID_BITS = 4
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  in_t     in_data,
    input  cmd_t    cmd,
    output status_t status,
    input  logic    out_ready,
    output logic    out_valid,
    output out_t    out_data
);

    localparam int AW = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(WORDS - 1);

    typedef struct packed {
        logic                  vsel;
        logic                  written;
        logic [TX_ID_BITS-1:0] writer;
        logic [TX_ID_BITS-1:0] reader;
        logic                  many;
    } meta_t;

    meta_t                meta_mem  [WORDS];
    logic [WORD_BITS-1:0] copy0_mem [WORDS];
    logic [WORD_BITS-1:0] copy1_mem [WORDS];

    in_t                  item_reg;
    logic [AW-1:0]        cnt_reg;
    logic [AW-1:0]        cnt_next;
    meta_t                meta_rd_reg;
    logic [WORD_BITS-1:0] copy0_rd_reg;
    logic [WORD_BITS-1:0] copy1_rd_reg;
    logic                 wb_valid_reg;
    logic [AW-1:0]        wb_addr_reg;
    logic                 out_valid_reg;
    out_t                 out_reg;

    logic [TX_ID_BITS-1:0] tx;
    logic [AW-1:0]         item_addr;
    logic                  in_range;
    logic [AW-1:0]         rd_addr;
    logic [WORD_BITS-1:0]  valid_copy;
    logic [WORD_BITS-1:0]  pend_copy;
    logic [WORD_BITS-1:0]  wdata;
    logic [WORD_BITS-1:0]  rdata;
    logic                  ok;
    meta_t                 meta_new;
    logic                  meta_upd;
    logic                  copy_upd;
    logic                  meta_we;
    logic [AW-1:0]         meta_waddr;
    meta_t                 meta_wdata;
    logic                  copy0_we;
    logic                  copy1_we;
    logic [AW-1:0]         copy_waddr;
    logic [WORD_BITS-1:0]  copy_wdata;
    logic                  out_free;

    assign tx         = TX_ID_BITS'(item_reg.tx_id);
    assign item_addr  = AW'(item_reg.word_index);
    assign in_range   = 32'(item_reg.word_index) < WORDS;
    assign rd_addr    = cmd.sweep_rd ? cnt_reg : item_addr;
    assign wdata      = WORD_BITS'(item_reg.write_data);
    assign valid_copy = meta_rd_reg.vsel ? copy1_rd_reg : copy0_rd_reg;
    assign pend_copy  = meta_rd_reg.vsel ? copy0_rd_reg : copy1_rd_reg;

    // access decision on the registered record
    always_comb
    begin
        ok       = 1'b0;
        rdata    = '0;
        meta_new = meta_rd_reg;
        meta_upd = 1'b0;
        copy_upd = 1'b0;
        unique case (item_reg.kind)
            KIND_READ:
            begin
                if (in_range)
                begin
                    if (item_reg.read_only)
                    begin
                        ok    = 1'b1;
                        rdata = valid_copy;
                    end
                    else if (meta_rd_reg.written)
                    begin
                        if (meta_rd_reg.writer == tx)
                        begin
                            ok    = 1'b1;
                            rdata = pend_copy;
                        end
                    end
                    else
                    begin
                        ok    = 1'b1;
                        rdata = valid_copy;
                        if (!meta_rd_reg.many)
                        begin
                            if (meta_rd_reg.reader == '0)
                            begin
                                meta_new.reader = tx;
                                meta_upd        = 1'b1;
                            end
                            else if (meta_rd_reg.reader != tx)
                            begin
                                meta_new.many = 1'b1;
                                meta_upd      = 1'b1;
                            end
                        end
                    end
                end
            end
            KIND_WRITE:
            begin
                if (in_range && !item_reg.read_only)
                begin
                    if (meta_rd_reg.written)
                    begin
                        if (meta_rd_reg.writer == tx)
                        begin
                            ok       = 1'b1;
                            copy_upd = 1'b1;
                        end
                    end
                    else if (!meta_rd_reg.many &&
                             (meta_rd_reg.reader == '0 || meta_rd_reg.reader == tx))
                    begin
                        ok               = 1'b1;
                        copy_upd         = 1'b1;
                        meta_new.writer  = tx;
                        meta_new.written = 1'b1;
                        meta_upd         = 1'b1;
                    end
                end
            end
            KIND_EPOCH:
            begin
                ok = 1'b1;
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase
    end

    // record write port: reset clear, sweep writeback, or access commit
    always_comb
    begin
        meta_we    = 1'b0;
        meta_waddr = item_addr;
        meta_wdata = meta_new;
        if (cmd.clear_wr)
        begin
            meta_we    = 1'b1;
            meta_waddr = cnt_reg;
            meta_wdata = '0;
        end
        else if (wb_valid_reg)
        begin
            meta_we         = 1'b1;
            meta_waddr      = wb_addr_reg;
            meta_wdata      = '0;
            meta_wdata.vsel = meta_rd_reg.vsel ^ meta_rd_reg.written;
        end
        else if (cmd.commit && meta_upd)
        begin
            meta_we = 1'b1;
        end
    end

    // pending copy is the one not selected
    assign copy0_we   = cmd.clear_wr || (cmd.commit && copy_upd && meta_rd_reg.vsel);
    assign copy1_we   = cmd.clear_wr || (cmd.commit && copy_upd && !meta_rd_reg.vsel);
    assign copy_waddr = cmd.clear_wr ? cnt_reg : item_addr;
    assign copy_wdata = cmd.clear_wr ? '0 : wdata;

    always_ff @(posedge clk)
    begin
        if (meta_we)
        begin
            meta_mem[meta_waddr] <= meta_wdata;
        end
        if (cmd.mem_read || cmd.sweep_rd)
        begin
            meta_rd_reg <= meta_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (copy0_we)
        begin
            copy0_mem[copy_waddr] <= copy_wdata;
        end
        if (cmd.mem_read)
        begin
            copy0_rd_reg <= copy0_mem[item_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (copy1_we)
        begin
            copy1_mem[copy_waddr] <= copy_wdata;
        end
        if (cmd.mem_read)
        begin
            copy1_rd_reg <= copy1_mem[item_addr];
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.cnt_clr)
        begin
            cnt_next = '0;
        end
        else if (cmd.cnt_inc)
        begin
            cnt_next = AW'(cnt_reg + AW'(1));
        end
    end

    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            wb_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg      <= cnt_next;
            wb_valid_reg <= cmd.sweep_rd;
            if (cmd.result_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg <= in_data;
        end
        if (cmd.sweep_rd)
        begin
            wb_addr_reg <= cnt_reg;
        end
        if (cmd.result_load)
        begin
            out_reg.read_data <= 64'(rdata);
            out_reg.ok        <= ok;
        end
    end

    assign status.cnt_last   = (cnt_reg == LAST_ADDR);
    assign status.item_epoch = (item_reg.kind == KIND_EPOCH);
    assign status.out_free   = out_free;
    assign out_valid         = out_valid_reg;
    assign out_data          = out_reg;

    `DVWC_ASSERT_IMPL(a_wb_after_sweep_read, wb_valid_reg, $past(cmd.sweep_rd), "writeback without sweep read")
    `DVWC_ASSERT_IMPL(a_single_copy_write, copy0_we && copy1_we, cmd.clear_wr, "both copies written outside clearing")
    `DVWC_ASSERT_NEXT(a_result_shown, cmd.result_load, out_valid_reg, "loaded result not presented")

endmodule

FILE: test/tb_dual_version_word_conflict_table_core.sv
// ----------------------------------------------------------------------------
// Dual version word conflict table - testbench
// Drives read, write, epoch-end and unused-kind words into the core. A local
// model of the two-copy store and its per-word reader/writer records predicts
// every result word, which is checked field by field. A directed table comes
// first, then random transaction traffic under several idle/stall mixes.
// ----------------------------------------------------------------------------
module tb_dual_version_word_conflict_table_core
    import dvwc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WORDS = 256;
    localparam int CYCLE_LIMIT = 200000;
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam logic [63:0] ALL_ONES = {64{1'b1}};

    typedef struct {
        in_t  word;
        bit   fixed;
        out_t want;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    in_t  in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_t out_data;

    // model of the store and its records
    logic [63:0] store_copy [2][WORDS];
    bit          valid_sel [WORDS];
    bit          written [WORDS];
    logic [3:0]  writer [WORDS];
    logic [3:0]  reader [WORDS];
    bit          multi_read [WORDS];

    out_t replies_due [$];
    int   mismatches = 0;
    int   cycles = 0;
    int   idle_pct = 0;
    int   stall_pct = 0;

    // last non-read-only read, reused to build read-modify-write pairs
    bit         have_last = 1'b0;
    logic [3:0] last_tx;
    logic [7:0] last_word;

    dual_version_word_conflict_table_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic out_t apply_to_store(in_t w);
        out_t r;
        int   i;
        bit   vsel;
        r = '0;
        i = int'(w.word_index);
        if (w.kind == KIND_EPOCH)
        begin
            for (int k = 0; k < WORDS; k++)
            begin
                if (written[k])
                    valid_sel[k] = !valid_sel[k];
                written[k] = 1'b0;
                writer[k] = '0;
                reader[k] = '0;
                multi_read[k] = 1'b0;
            end
            r.ok = 1'b1;
        end
        else if ((w.kind == KIND_READ || w.kind == KIND_WRITE) && i < WORDS)
        begin
            vsel = valid_sel[i];
            if (w.kind == KIND_READ)
            begin
                if (w.read_only)
                begin
                    r.read_data = store_copy[vsel][i];
                    r.ok = 1'b1;
                end
                else if (written[i])
                begin
                    if (writer[i] == w.tx_id)
                    begin
                        r.read_data = store_copy[!vsel][i];
                        r.ok = 1'b1;
                    end
                end
                else
                begin
                    r.read_data = store_copy[vsel][i];
                    r.ok = 1'b1;
                    // tx 0 recorded as sole reader leaves the record at none
                    if (!multi_read[i])
                    begin
                        if (reader[i] == '0)
                            reader[i] = w.tx_id;
                        else if (reader[i] != w.tx_id)
                            multi_read[i] = 1'b1;
                    end
                end
            end
            else if (!w.read_only)
            begin
                if (written[i])
                begin
                    if (writer[i] == w.tx_id)
                    begin
                        store_copy[!vsel][i] = w.write_data;
                        r.ok = 1'b1;
                    end
                end
                else if (!multi_read[i] && (reader[i] == '0 || reader[i] == w.tx_id))
                begin
                    store_copy[!vsel][i] = w.write_data;
                    writer[i] = w.tx_id;
                    written[i] = 1'b1;
                    r.ok = 1'b1;
                end
            end
        end
        return r;
    endfunction

    function automatic dir_row_t row(logic [1:0] k, logic [3:0] tx, logic ro,
                                     logic [7:0] idx, logic [63:0] d, bit fixed,
                                     logic [63:0] rd, logic ok);
        dir_row_t t;
        t.word.kind = k;
        t.word.tx_id = tx;
        t.word.read_only = ro;
        t.word.word_index = idx;
        t.word.write_data = d;
        t.fixed = fixed;
        t.want.read_data = rd;
        t.want.ok = ok;
        return t;
    endfunction

    function automatic in_t make_random_word();
        in_t w;
        int  roll;
        w.kind = KIND_READ;
        w.tx_id = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                              : 4'($urandom_range(1, 4));
        w.read_only = 1'b0;
        // hot set of words so records collide often
        if ($urandom_range(0, 3) != 0)
            w.word_index = 8'($urandom_range(0, 7) * 36 + (($urandom_range(0, 7) == 7) ? 3 : 0));
        else
            w.word_index = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 9))
            0: w.write_data = ALL_ONES;
            1: w.write_data = '0;
            default: w.write_data = {$urandom, $urandom};
        endcase
        roll = $urandom_range(0, 99);
        if (roll < 4)
            w.kind = KIND_EPOCH;
        else if (roll < 6)
            w.kind = KIND_UNUSED;
        else if (roll < 40 && have_last)
        begin
            w.kind = KIND_WRITE;
            w.tx_id = last_tx;
            w.word_index = last_word;
            have_last = 1'b0;
        end
        else if (roll < 60)
        begin
            w.kind = KIND_WRITE;
            w.read_only = ($urandom_range(0, 19) == 0);
        end
        else
        begin
            w.read_only = ($urandom_range(0, 5) == 0);
            if (!w.read_only)
            begin
                have_last = 1'b1;
                last_tx = w.tx_id;
                last_word = w.word_index;
            end
        end
        // epoch end ignores these; vary them anyway
        if (w.kind == KIND_EPOCH || w.kind == KIND_UNUSED)
            w.read_only = 1'($urandom_range(0, 1));
        return w;
    endfunction

    task automatic issue(in_t w, bit fixed, out_t want);
        out_t predicted;
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= w;
        do
            @(posedge clk);
        while (!in_ready);
        predicted = apply_to_store(w);
        replies_due.push_back(fixed ? want : predicted);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (replies_due.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin : reply_check
        out_t want;
        if (rst_n)
        begin
            out_ready <= ($urandom_range(0, 99) >= stall_pct);
            if (out_valid && out_ready)
            begin
                if (replies_due.size() == 0)
                begin
                    $display("%0t: unexpected word: read_data=%h ok=%b",
                             $time, out_data.read_data, out_data.ok);
                    mismatches++;
                end
                else
                begin
                    want = replies_due.pop_front();
                    if (out_data.read_data !== want.read_data)
                    begin
                        $display("%0t: read_data expected %h actual %h",
                                 $time, want.read_data, out_data.read_data);
                        mismatches++;
                    end
                    if (out_data.ok !== want.ok)
                    begin
                        $display("%0t: ok expected %b actual %b",
                                 $time, want.ok, out_data.ok);
                        mismatches++;
                    end
                end
            end
        end
    end

    initial
    begin
        dir_row_t dir_rows [$];
        out_t     none;
        none = '0;
        for (int k = 0; k < WORDS; k++)
        begin
            store_copy[0][k] = '0;
            store_copy[1][k] = '0;
            valid_sel[k] = 1'b0;
            written[k] = 1'b0;
            writer[k] = '0;
            reader[k] = '0;
            multi_read[k] = 1'b0;
        end

        // after reset both copies read as zero
        dir_rows.push_back(row(KIND_READ, 4'd1, 1'b0, 8'd0, '0, 1, '0, 1'b1));
        dir_rows.push_back(row(KIND_READ, 4'd15, 1'b1, 8'd255, ALL_ONES, 1, '0, 1'b1));
        // read-only writer is refused
        dir_rows.push_back(row(KIND_WRITE, 4'd1, 1'b1, 8'd5, ALL_ONES, 1, '0, 1'b0));
        dir_rows.push_back(row(KIND_UNUSED, 4'd3, 1'b0, 8'd6, ALL_ONES, 1, '0, 1'b0));
        // word 0 has reader tx1: others may not write, tx1 may
        dir_rows.push_back(row(KIND_WRITE, 4'd2, 1'b0, 8'd0, 64'd5, 1, '0, 1'b0));
        dir_rows.push_back(row(KIND_WRITE, 4'd1, 1'b0, 8'd0, ALL_ONES, 1, '0, 1'b1));
        dir_rows.push_back(row(KIND_READ, 4'd1, 1'b0, 8'd0, '0, 1, ALL_ONES, 1'b1));
        dir_rows.push_back(row(KIND_READ, 4'd2, 1'b0, 8'd0, '0, 1, '0, 1'b0));
        dir_rows.push_back(row(KIND_READ, 4'd2, 1'b1, 8'd0, '0, 1, '0, 1'b1));
        dir_rows.push_back(row(KIND_WRITE, 4'd1, 1'b0, 8'd0, 64'h0123_4567_89ab_cdef,
                               0, '0, 1'b0));
        dir_rows.push_back(row(KIND_WRITE, 4'd3, 1'b0, 8'd255, 64'h8000_0000_0000_0001,
                               0, '0, 1'b0));
        // two readers, then a write by one of them aborts
        dir_rows.push_back(row(KIND_READ, 4'd4, 1'b0, 8'd7, '0, 0, '0, 1'b0));
        dir_rows.push_back(row(KIND_READ, 4'd5, 1'b0, 8'd7, '0, 0, '0, 1'b0));
        dir_rows.push_back(row(KIND_WRITE, 4'd4, 1'b0, 8'd7, 64'h55, 0, '0, 1'b0));
        // tx 0 as reader leaves no record
        dir_rows.push_back(row(KIND_READ, 4'd0, 1'b0, 8'd9, '0, 0, '0, 1'b0));
        dir_rows.push_back(row(KIND_WRITE, 4'd6, 1'b0, 8'd9, 64'hfedc_ba98_7654_3210,
                               0, '0, 1'b0));
        dir_rows.push_back(row(KIND_READ, 4'd6, 1'b0, 8'd9, '0, 0, '0, 1'b0));
        dir_rows.push_back(row(KIND_EPOCH, 4'd15, 1'b1, 8'd200, ALL_ONES, 1, '0, 1'b1));
        // committed values, including the aborted tx2 context on word 0
        dir_rows.push_back(row(KIND_READ, 4'd2, 1'b0, 8'd0, '0, 0, '0, 1'b0));
        dir_rows.push_back(row(KIND_READ, 4'd8, 1'b1, 8'd255, '0, 0, '0, 1'b0));
        dir_rows.push_back(row(KIND_WRITE, 4'd7, 1'b0, 8'd7, '0, 0, '0, 1'b0));
        dir_rows.push_back(row(KIND_READ, 4'd9, 1'b0, 8'd9, '0, 0, '0, 1'b0));
        dir_rows.push_back(row(KIND_EPOCH, 4'd0, 1'b0, 8'd0, '0, 1, '0, 1'b1));
        dir_rows.push_back(row(KIND_READ, 4'd0, 1'b0, 8'd7, '0, 0, '0, 1'b0));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[r])
            issue(dir_rows[r].word, dir_rows[r].fixed, dir_rows[r].want);
        // hold off until every result is back
        drain();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 67; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 67; end
                default: begin idle_pct = 35; stall_pct = 35; end
            endcase
            repeat (112)
                issue(make_random_word(), 1'b0, none);
            drain();
        end

        stall_pct = 0;
        repeat (WORDS + 8) @(posedge clk);
        if (mismatches == 0 && replies_due.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
